// ===== src/bfpa_pkg.sv =====
package bfpa_pkg;

    // request commands
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // response status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // datapath operations driven by the controller
    localparam logic [2:0] OP_IDLE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_CHECK  = 3'd2;
    localparam logic [2:0] OP_SCAN   = 3'd3;
    localparam logic [2:0] OP_DECIDE = 3'd4;
    localparam logic [2:0] OP_SHDN   = 3'd5;
    localparam logic [2:0] OP_SHUP   = 3'd6;
    localparam logic [2:0] OP_FINISH = 3'd7;

    // what follows the decision step
    localparam logic [1:0] PATH_DONE = 2'd0;
    localparam logic [1:0] PATH_SHDN = 2'd1;
    localparam logic [1:0] PATH_SHUP = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [16:0] page_count;
        logic [15:0] base_page;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_page;
        logic [16:0] free_total;
    } rsp_t;

    typedef struct packed {
        logic [2:0] op;
    } ctrl_t;

    typedef struct packed {
        logic       quick;
        logic       scan_done;
        logic       shift_done;
        logic       out_free;
        logic [1:0] path;
    } stat_t;

endpackage

// ===== src/bfpa_ram.sv =====
module bfpa_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/bfpa_ctrl.sv =====
module bfpa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bfpa_pkg::stat_t stat,
    output bfpa_pkg::ctrl_t ctrl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SHDN   = 3'd4;
    localparam logic [2:0] S_SHUP   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);

    // sequencing of one request
    always_comb
    begin
        state_next = state_reg;
        ctrl.op    = bfpa_pkg::OP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctrl.op    = bfpa_pkg::OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctrl.op    = bfpa_pkg::OP_CHECK;
                state_next = stat.quick ? S_DONE : S_SCAN;
            end
            S_SCAN:
            begin
                ctrl.op = bfpa_pkg::OP_SCAN;
                if (stat.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ctrl.op = bfpa_pkg::OP_DECIDE;
                case (stat.path)
                    bfpa_pkg::PATH_SHDN: state_next = S_SHDN;
                    bfpa_pkg::PATH_SHUP: state_next = S_SHUP;
                    default:             state_next = S_DONE;
                endcase
            end
            S_SHDN:
            begin
                ctrl.op = bfpa_pkg::OP_SHDN;
                if (stat.shift_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_SHUP:
            begin
                ctrl.op = bfpa_pkg::OP_SHUP;
                if (stat.shift_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                ctrl.op = bfpa_pkg::OP_FINISH;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/bfpa_dp.sv =====
module bfpa_dp #(
    parameter int PAGE_COUNT  = 65536,
    parameter int MAX_EXTENTS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bfpa_pkg::req_t  req,
    input  bfpa_pkg::ctrl_t ctrl,
    output bfpa_pkg::stat_t stat,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output bfpa_pkg::rsp_t  rsp
);

    localparam int AW    = $clog2(MAX_EXTENTS);
    localparam int SPACE = (PAGE_COUNT < 65536) ? PAGE_COUNT : 65536;
    localparam logic [AW:0] MAX_CNT = (AW + 1)'(MAX_EXTENTS);

    // request and table bookkeeping
    logic [1:0]  cmd_reg;
    logic [16:0] n_reg, n_next;
    logic [15:0] base_reg;
    logic [AW:0] used_reg, used_next;
    logic [16:0] free_reg, free_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic [AW:0] pos_reg, pos_next;
    logic        rd_valid_reg, rd_valid_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic        stop_reg, stop_next;
    logic        found_reg, found_next;
    logic [AW-1:0] pick_reg, pick_next;
    logic [15:0] pick_start_reg, pick_start_next;
    logic [16:0] pick_len_reg, pick_len_next;
    logic        prev_valid_reg, prev_valid_next;
    logic [15:0] prev_start_reg, prev_start_next;
    logic [16:0] prev_len_reg, prev_len_next;
    logic        next_valid_reg, next_valid_next;
    logic [15:0] next_start_reg, next_start_next;
    logic [16:0] next_len_reg, next_len_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] granted_reg, granted_next;
    logic        out_valid_reg;
    bfpa_pkg::rsp_t out_reg;

    // table memory
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [32:0]   wdata, rdata;
    logic [15:0]   rd_start;
    logic [16:0]   rd_len;

    bfpa_ram #(.WIDTH(33), .DEPTH(MAX_EXTENTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_start = rdata[32:17];
    assign rd_len   = rdata[16:0];

    // decision arithmetic
    logic [17:0] prev_end, new_end;
    logic        lo, hi, ov_lo, ov_hi;
    logic        alloc_bad, free_skip;

    assign prev_end  = {2'b0, prev_start_reg} + {1'b0, prev_len_reg};
    assign new_end   = {2'b0, base_reg} + {1'b0, n_reg};
    assign lo        = prev_valid_reg && (prev_end == {2'b0, base_reg});
    assign ov_lo     = prev_valid_reg && (prev_end > {2'b0, base_reg});
    assign hi        = next_valid_reg && (new_end == {2'b0, next_start_reg});
    assign ov_hi     = next_valid_reg && (new_end > {2'b0, next_start_reg});
    assign alloc_bad = (n_reg == 17'd0) || (n_reg > free_reg);
    assign free_skip = (n_reg == 17'd0) || ({2'b0, base_reg} >= 18'(SPACE));

    always_comb
    begin
        stat.quick = (cmd_reg == bfpa_pkg::CMD_CLEAR) || (cmd_reg == bfpa_pkg::CMD_NOP)
                  || ((cmd_reg == bfpa_pkg::CMD_ALLOC) && alloc_bad)
                  || ((cmd_reg == bfpa_pkg::CMD_FREE) && free_skip);
        stat.scan_done  = !rd_valid_reg && ((cnt_reg >= used_reg) || stop_reg);
        // an insert opens a slot upward, everything else closes a gap downward
        stat.shift_done = ((cmd_reg == bfpa_pkg::CMD_FREE) && !lo && !hi)
                        ? (!rd_valid_reg && (cnt_reg == pos_reg))
                        : (!rd_valid_reg && (cnt_reg > used_reg));
        stat.out_free   = !out_valid_reg || !rsp_stall;
        stat.path       = bfpa_pkg::PATH_DONE;
        if (cmd_reg == bfpa_pkg::CMD_ALLOC)
        begin
            if (found_reg && (pick_len_reg == n_reg))
            begin
                stat.path = bfpa_pkg::PATH_SHDN;
            end
        end
        else if (!ov_lo && !ov_hi)
        begin
            if (lo && hi)
            begin
                stat.path = bfpa_pkg::PATH_SHDN;
            end
            else if (!lo && !hi && (used_reg < MAX_CNT))
            begin
                stat.path = bfpa_pkg::PATH_SHUP;
            end
        end
    end

    // next state of the datapath per operation
    always_comb
    begin
        n_next          = n_reg;
        used_next       = used_reg;
        free_next       = free_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        rd_valid_next   = 1'b0;
        rd_idx_next     = rd_idx_reg;
        stop_next       = stop_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        pick_start_next = pick_start_reg;
        pick_len_next   = pick_len_reg;
        prev_valid_next = prev_valid_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        next_valid_next = next_valid_reg;
        next_start_next = next_start_reg;
        next_len_next   = next_len_reg;
        status_next     = status_reg;
        granted_next    = granted_reg;
        we              = 1'b0;
        waddr           = '0;
        wdata           = '0;
        raddr           = cnt_reg[AW-1:0];
        case (ctrl.op)
            bfpa_pkg::OP_LOAD:
            begin
                n_next          = req.page_count;
                cnt_next        = '0;
                pos_next        = used_reg;
                stop_next       = 1'b0;
                found_next      = 1'b0;
                prev_valid_next = 1'b0;
                next_valid_next = 1'b0;
                status_next     = bfpa_pkg::ST_OK;
                granted_next    = '0;
            end
            bfpa_pkg::OP_CHECK:
            begin
                if (cmd_reg == bfpa_pkg::CMD_CLEAR)
                begin
                    used_next = '0;
                    free_next = '0;
                end
                if ((cmd_reg == bfpa_pkg::CMD_ALLOC) && alloc_bad)
                begin
                    status_next = bfpa_pkg::ST_NOFIT;
                end
                // clip a free at the end of the page space
                if ((cmd_reg == bfpa_pkg::CMD_FREE) && (new_end > 18'(SPACE)))
                begin
                    n_next = 17'(18'(SPACE) - {2'b0, base_reg});
                end
            end
            bfpa_pkg::OP_SCAN:
            begin
                if (rd_valid_reg)
                begin
                    if (cmd_reg == bfpa_pkg::CMD_ALLOC)
                    begin
                        if ((rd_len >= n_reg) && (!found_reg || (rd_len < pick_len_reg)))
                        begin
                            found_next      = 1'b1;
                            pick_next       = rd_idx_reg;
                            pick_start_next = rd_start;
                            pick_len_next   = rd_len;
                        end
                    end
                    else if (!stop_reg)
                    begin
                        if (rd_start <= base_reg)
                        begin
                            prev_valid_next = 1'b1;
                            prev_start_next = rd_start;
                            prev_len_next   = rd_len;
                        end
                        else
                        begin
                            next_valid_next = 1'b1;
                            next_start_next = rd_start;
                            next_len_next   = rd_len;
                            pos_next        = {1'b0, rd_idx_reg};
                            stop_next       = 1'b1;
                        end
                    end
                end
                if ((cnt_reg < used_reg) && !stop_next)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = cnt_reg[AW-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            bfpa_pkg::OP_DECIDE:
            begin
                if (cmd_reg == bfpa_pkg::CMD_ALLOC)
                begin
                    if (!found_reg)
                    begin
                        status_next = bfpa_pkg::ST_NOFIT;
                    end
                    else
                    begin
                        granted_next = pick_start_reg;
                        free_next    = free_reg - n_reg;
                        if (pick_len_reg > n_reg)
                        begin
                            we    = 1'b1;
                            waddr = pick_reg;
                            wdata = {16'(pick_start_reg + n_reg[15:0]), pick_len_reg - n_reg};
                        end
                        else
                        begin
                            used_next = used_reg - 1'b1;
                            cnt_next  = {1'b0, pick_reg} + 1'b1;
                        end
                    end
                end
                else if (!ov_lo && !ov_hi)
                begin
                    if (lo && hi)
                    begin
                        we        = 1'b1;
                        waddr     = AW'(pos_reg - 1'b1);
                        wdata     = {prev_start_reg, 17'(prev_len_reg + n_reg + next_len_reg)};
                        used_next = used_reg - 1'b1;
                        cnt_next  = pos_reg + 1'b1;
                        free_next = free_reg + n_reg;
                    end
                    else if (lo)
                    begin
                        we        = 1'b1;
                        waddr     = AW'(pos_reg - 1'b1);
                        wdata     = {prev_start_reg, 17'(prev_len_reg + n_reg)};
                        free_next = free_reg + n_reg;
                    end
                    else if (hi)
                    begin
                        we        = 1'b1;
                        waddr     = pos_reg[AW-1:0];
                        wdata     = {base_reg, 17'(next_len_reg + n_reg)};
                        free_next = free_reg + n_reg;
                    end
                    else if (used_reg >= MAX_CNT)
                    begin
                        status_next = bfpa_pkg::ST_FULL;
                    end
                    else
                    begin
                        cnt_next  = used_reg;
                        free_next = free_reg + n_reg;
                    end
                end
            end
            bfpa_pkg::OP_SHDN:
            begin
                // move entries above the dropped one down by one
                if (rd_valid_reg)
                begin
                    we    = 1'b1;
                    waddr = rd_idx_reg - 1'b1;
                    wdata = rdata;
                end
                if (cnt_reg <= used_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = cnt_reg[AW-1:0];
                    cnt_next      = cnt_reg + 1'b1;
                end
            end
            bfpa_pkg::OP_SHUP:
            begin
                // open a slot at pos, top entry first
                raddr = AW'(cnt_reg - 1'b1);
                if (rd_valid_reg)
                begin
                    we    = 1'b1;
                    waddr = rd_idx_reg + 1'b1;
                    wdata = rdata;
                end
                else if (cnt_reg == pos_reg)
                begin
                    we        = 1'b1;
                    waddr     = pos_reg[AW-1:0];
                    wdata     = {base_reg, n_reg};
                    used_next = used_reg + 1'b1;
                end
                if (cnt_reg > pos_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = AW'(cnt_reg - 1'b1);
                    cnt_next      = cnt_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            free_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            free_reg     <= free_next;
            rd_valid_reg <= rd_valid_next;
            if ((ctrl.op == bfpa_pkg::OP_FINISH) && stat.out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.op == bfpa_pkg::OP_LOAD)
        begin
            cmd_reg  <= req.command;
            base_reg <= req.base_page;
        end
        n_reg           <= n_next;
        cnt_reg         <= cnt_next;
        pos_reg         <= pos_next;
        rd_idx_reg      <= rd_idx_next;
        stop_reg        <= stop_next;
        found_reg       <= found_next;
        pick_reg        <= pick_next;
        pick_start_reg  <= pick_start_next;
        pick_len_reg    <= pick_len_next;
        prev_valid_reg  <= prev_valid_next;
        prev_start_reg  <= prev_start_next;
        prev_len_reg    <= prev_len_next;
        next_valid_reg  <= next_valid_next;
        next_start_reg  <= next_start_next;
        next_len_reg    <= next_len_next;
        status_reg      <= status_next;
        granted_reg     <= granted_next;
        if ((ctrl.op == bfpa_pkg::OP_FINISH) && stat.out_free)
        begin
            out_reg.status       <= status_reg;
            out_reg.granted_page <= granted_reg;
            out_reg.free_total   <= free_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

// ===== src/best_fit_page_allocator_core.sv =====
// Best-fit page allocator with an address-ordered extent table.
// Request channel (req_valid, req_stall, req): one beat carries command,
// page_count and base_page. Response channel (rsp_valid, rsp_stall, rsp):
// exactly one beat per request with status, granted_page and free_total.
// Requests are handled one at a time; req_stall is high from acceptance
// until the response is loaded into the output register.
// Commands decided without the table (clear, no-op, rejected allocations,
// empty or out-of-range frees) go from the check straight to the output;
// others run a pipelined scan of the table (a free stops early at the first
// entry above its base), a decision step and, when an entry is removed or
// inserted, a shift of the entries above it, one entry per cycle.
// req_stall falls as the response is loaded; the next request is then taken.
// The table memory has one write port: one entry is read and one moved
// each cycle of a shift.
// Reset empties the table and zeroes the free total at once; no sweep.
// When rsp_stall is high the response holds; the next request may still be
// accepted and worked on, and waits in its final state for the output.
module best_fit_page_allocator_core #(
    parameter int PAGE_COUNT  = 65536,
    parameter int MAX_EXTENTS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bfpa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bfpa_pkg::rsp_t rsp
);

    bfpa_pkg::ctrl_t ctrl;
    bfpa_pkg::stat_t stat;

    bfpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    bfpa_dp #(
        .PAGE_COUNT  (PAGE_COUNT),
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .ctrl      (ctrl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== src/bfpa_checker.sv =====
module bfpa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input bfpa_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input bfpa_pkg::rsp_t rsp
);

    // a stalled response beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // only defined status codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= bfpa_pkg::ST_FULL)
        else $error("undefined status");

    // a beat with a failure status grants nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != bfpa_pkg::ST_OK |-> rsp.granted_page == 16'd0)
        else $error("grant on failure");

    // free total never exceeds 65536, the largest page space
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.free_total <= 17'd65536)
        else $error("free total out of range");

    // an accepted request blocks a back-to-back accept of the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("back to back accept");

endmodule

bind best_fit_page_allocator_core bfpa_checker u_bfpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
